FILE: hw/rtl/vc2sh_pkg.sv
// ----------------------------------------------------------------------------
// VC-2 sequence header parser package
// Shared command and status types, result codes, register indexes and the
// base video format size table.
// ----------------------------------------------------------------------------
`default_nettype none

package vc2sh_pkg;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // take a new header byte into the shift register
      logic bit_step;   // feed the next byte bit to the parser
      logic pad_step;   // feed a padding 1 bit to the parser
      logic emit;       // write the result and restart the parse
   } vc2sh_cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic done;       // parse has reached its end
      logic out_free;   // result register can take a new result
   } vc2sh_stat_type;

   // Result status codes
   localparam logic [1:0] RSP_OK          = 2'd0;
   localparam logic [1:0] RSP_BAD_VERSION = 2'd1;
   localparam logic [1:0] RSP_BAD_FORMAT  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_MAJOR   = 1'b0;
   localparam logic CSR_PROFILE = 1'b1;

   // Configuration reset values
   localparam logic [7:0] MAJOR_RESET   = 8'd2;
   localparam logic [7:0] PROFILE_RESET = 8'd3;

   // Base video format table
   localparam int          FORMAT_COUNT = 23;
   localparam int          SIZE_WIDTH   = 13;

   function automatic logic [SIZE_WIDTH-1:0] fmt_width(input logic [4:0] idx);
      logic [SIZE_WIDTH-1:0] w;
      unique case (idx)
         5'd0:    w = 13'd640;
         5'd1:    w = 13'd176;
         5'd2:    w = 13'd176;
         5'd3:    w = 13'd352;
         5'd4:    w = 13'd352;
         5'd5:    w = 13'd704;
         5'd6:    w = 13'd704;
         5'd7:    w = 13'd720;
         5'd8:    w = 13'd720;
         5'd9:    w = 13'd1280;
         5'd10:   w = 13'd1280;
         5'd11:   w = 13'd1920;
         5'd12:   w = 13'd1920;
         5'd13:   w = 13'd1920;
         5'd14:   w = 13'd1920;
         5'd15:   w = 13'd2048;
         5'd16:   w = 13'd4096;
         5'd17:   w = 13'd3840;
         5'd18:   w = 13'd3840;
         5'd19:   w = 13'd7680;
         5'd20:   w = 13'd7680;
         5'd21:   w = 13'd1920;
         5'd22:   w = 13'd720;
         default: w = 13'd0;
      endcase
      return w;
   endfunction

   function automatic logic [SIZE_WIDTH-1:0] fmt_height(input logic [4:0] idx);
      logic [SIZE_WIDTH-1:0] h;
      unique case (idx)
         5'd0:    h = 13'd480;
         5'd1:    h = 13'd120;
         5'd2:    h = 13'd144;
         5'd3:    h = 13'd240;
         5'd4:    h = 13'd288;
         5'd5:    h = 13'd480;
         5'd6:    h = 13'd576;
         5'd7:    h = 13'd480;
         5'd8:    h = 13'd576;
         5'd9:    h = 13'd720;
         5'd10:   h = 13'd720;
         5'd11:   h = 13'd1080;
         5'd12:   h = 13'd1080;
         5'd13:   h = 13'd1080;
         5'd14:   h = 13'd1080;
         5'd15:   h = 13'd1080;
         5'd16:   h = 13'd2160;
         5'd17:   h = 13'd2160;
         5'd18:   h = 13'd2160;
         5'd19:   h = 13'd4320;
         5'd20:   h = 13'd4320;
         5'd21:   h = 13'd1080;
         5'd22:   h = 13'd486;
         default: h = 13'd0;
      endcase
      return h;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vc2sh_ctrl.sv
// ----------------------------------------------------------------------------
// VC-2 sequence header parser controller
// Sequences the byte handshake, the eight bit steps of each byte, the
// padding bits after the last byte and the hand-off of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vc2sh_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire                       req_tlast,
   input  vc2sh_pkg::vc2sh_stat_type stat,
   output vc2sh_pkg::vc2sh_cmd_type  cmd
);
   import vc2sh_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BITS,
      S_PAD,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;

   // Decode commands and next state
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               last_in  = req_tlast;
               cnt_in   = 3'd0;
               state_in = S_BITS;
            end
         end
         S_BITS: begin
            cmd.bit_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               if (last_ff) begin
                  state_in = S_PAD;
               end else begin
                  // take the next beat while the final bit goes in
                  req_tready = 1'b1;
                  if (req_tvalid) begin
                     cmd.load = 1'b1;
                     last_in  = req_tlast;
                     state_in = S_BITS;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_PAD: begin
            if (stat.done) begin
               state_in = S_EMIT;
            end else begin
               cmd.pad_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result written while result register full");
   a_pad_open: assert property (@(posedge clock) disable iff (reset)
      cmd.pad_step |-> !stat.done)
      else $error("padding bit issued after parse end");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/vc2sh_dpath.sv
// ----------------------------------------------------------------------------
// VC-2 sequence header parser datapath
// Bit-serial exp-Golomb decoder and field sequencer, frame size registers,
// format table lookup and the result payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module vc2sh_dpath #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  vc2sh_pkg::vc2sh_cmd_type cmd,
   input  wire  [7:0]               header_byte,
   input  wire  [7:0]               required_major,
   input  wire  [7:0]               required_profile,
   output logic                     done,
   output logic [1:0]               rsp_status,
   output logic [31:0]              rsp_width,
   output logic [31:0]              rsp_height,
   output logic                     rsp_interlaced
);
   import vc2sh_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] ONE = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

   typedef enum logic [5:0] {
      P_MAJOR, P_MINOR, P_PROFILE, P_LEVEL, P_FORMAT,
      P_CUSTOM, P_CUST_W, P_CUST_H,
      P_FLAG_A, P_SKIP_A, P_FLAG_B, P_SKIP_B,
      P_FLAG_C, P_SEL_C, P_SKIP_C,
      P_FLAG_D, P_SEL_D, P_SKIP_D,
      P_FLAG_E, P_SKIP_E,
      P_FLAG_F, P_SEL_F, P_SKIP_F,
      P_FLAG_G, P_SEL_G,
      P_SUB1, P_SKIP_S1, P_SUB2, P_SKIP_S2, P_SUB3, P_SKIP_S3,
      P_MODE, P_DONE
   } step_type;

   step_type               step_ff, step_in;
   logic [7:0]             shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [2:0]             skip_ff, skip_in;
   logic [VALUE_WIDTH-1:0] width_ff, width_in;
   logic [VALUE_WIDTH-1:0] height_ff, height_in;
   logic                   fmt_bad_ff, fmt_bad_in;
   logic                   done_ff, done_in;
   logic                   data_ff, data_in;
   logic                   ver_bad_ff, ver_bad_in;
   logic                   ilace_ff, ilace_in;
   logic [1:0]             status_ff, status_in;
   logic [31:0]            rwidth_ff, rwidth_in;
   logic [31:0]            rheight_ff, rheight_in;
   logic                   rilace_ff, rilace_in;

   logic                   bit_val;
   logic                   is_flag;
   logic [VALUE_WIDTH-1:0] val;
   logic                   val_zero;
   logic                   fmt_ok;
   step_type               skip_next;
   logic [VALUE_WIDTH-1:0] half_h;
   logic [VALUE_WIDTH+31:0] w_ext;
   logic [VALUE_WIDTH+31:0] h_ext;

   assign bit_val  = cmd.pad_step | shift_ff[7];
   assign val      = acc_ff - ONE;
   assign val_zero = (val == '0);
   assign fmt_ok   = (val[VALUE_WIDTH-1:5] == '0) && (val[4:0] < 5'(FORMAT_COUNT));
   assign is_flag  = (step_ff == P_CUSTOM) || (step_ff == P_FLAG_A) ||
                     (step_ff == P_FLAG_B) || (step_ff == P_FLAG_C) ||
                     (step_ff == P_FLAG_D) || (step_ff == P_FLAG_E) ||
                     (step_ff == P_FLAG_F) || (step_ff == P_FLAG_G) ||
                     (step_ff == P_SUB1)   || (step_ff == P_SUB2)   ||
                     (step_ff == P_SUB3);
   assign half_h   = ilace_ff ? (height_ff >> 1) : height_ff;
   assign w_ext    = {32'd0, width_ff};
   assign h_ext    = {32'd0, half_h};

   // Field that follows the end of each skip run
   always_comb begin
      unique case (step_ff)
         P_SKIP_A:  skip_next = P_FLAG_B;
         P_SKIP_B:  skip_next = P_FLAG_C;
         P_SKIP_C:  skip_next = P_FLAG_D;
         P_SKIP_D:  skip_next = P_FLAG_E;
         P_SKIP_E:  skip_next = P_FLAG_F;
         P_SKIP_F:  skip_next = P_FLAG_G;
         P_SKIP_S1: skip_next = P_SUB2;
         P_SKIP_S2: skip_next = P_SUB3;
         default:   skip_next = P_MODE;
      endcase
   end

   // Parse one bit, load bytes, write the result
   always_comb begin
      step_in    = step_ff;
      shift_in   = shift_ff;
      acc_in     = acc_ff;
      skip_in    = skip_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      fmt_bad_in = fmt_bad_ff;
      done_in    = done_ff;
      data_in    = data_ff;
      ver_bad_in = ver_bad_ff;
      ilace_in   = ilace_ff;
      status_in  = status_ff;
      rwidth_in  = rwidth_ff;
      rheight_in = rheight_ff;
      rilace_in  = rilace_ff;

      if (cmd.load) begin
         shift_in = header_byte;
      end else if (cmd.bit_step) begin
         shift_in = {shift_ff[6:0], 1'b0};
      end

      if ((cmd.bit_step || cmd.pad_step) && !done_ff) begin
         if (is_flag) begin
            // flag bits branch directly
            unique case (step_ff)
               P_CUSTOM: step_in = bit_val ? P_CUST_W : P_FLAG_A;
               P_FLAG_A: begin
                  if (bit_val) begin
                     skip_in = 3'd1;
                     step_in = P_SKIP_A;
                  end else begin
                     step_in = P_FLAG_B;
                  end
               end
               P_FLAG_B: begin
                  if (bit_val) begin
                     skip_in = 3'd1;
                     step_in = P_SKIP_B;
                  end else begin
                     step_in = P_FLAG_C;
                  end
               end
               P_FLAG_C: step_in = bit_val ? P_SEL_C : P_FLAG_D;
               P_FLAG_D: step_in = bit_val ? P_SEL_D : P_FLAG_E;
               P_FLAG_E: begin
                  if (bit_val) begin
                     skip_in = 3'd4;
                     step_in = P_SKIP_E;
                  end else begin
                     step_in = P_FLAG_F;
                  end
               end
               P_FLAG_F: step_in = bit_val ? P_SEL_F : P_FLAG_G;
               P_FLAG_G: step_in = bit_val ? P_SEL_G : P_MODE;
               P_SUB1: begin
                  if (bit_val) begin
                     skip_in = 3'd1;
                     step_in = P_SKIP_S1;
                  end else begin
                     step_in = P_SUB2;
                  end
               end
               P_SUB2: begin
                  if (bit_val) begin
                     skip_in = 3'd1;
                     step_in = P_SKIP_S2;
                  end else begin
                     step_in = P_SUB3;
                  end
               end
               P_SUB3: begin
                  if (bit_val) begin
                     skip_in = 3'd1;
                     step_in = P_SKIP_S3;
                  end else begin
                     step_in = P_MODE;
                  end
               end
               default: ;
            endcase
         end else if (data_ff) begin
            // shift in a data bit of the current value
            acc_in  = {acc_ff[VALUE_WIDTH-2:0], bit_val};
            data_in = 1'b0;
         end else if (bit_val) begin
            // terminator: the value is complete
            acc_in = ONE;
            unique case (step_ff)
               P_MAJOR: begin
                  if (val != {{(VALUE_WIDTH-8){1'b0}}, required_major}) begin
                     ver_bad_in = 1'b1;
                  end
                  step_in = P_MINOR;
               end
               P_MINOR: step_in = P_PROFILE;
               P_PROFILE: begin
                  if (val != {{(VALUE_WIDTH-8){1'b0}}, required_profile}) begin
                     ver_bad_in = 1'b1;
                  end
                  step_in = P_LEVEL;
               end
               P_LEVEL: begin
                  if (ver_bad_ff) begin
                     step_in = P_DONE;
                     done_in = 1'b1;
                  end else begin
                     step_in = P_FORMAT;
                  end
               end
               P_FORMAT: begin
                  if (fmt_ok) begin
                     width_in   = {{(VALUE_WIDTH-SIZE_WIDTH){1'b0}}, fmt_width(val[4:0])};
                     height_in  = {{(VALUE_WIDTH-SIZE_WIDTH){1'b0}}, fmt_height(val[4:0])};
                     fmt_bad_in = 1'b0;
                  end else begin
                     width_in   = '0;
                     height_in  = '0;
                     fmt_bad_in = 1'b1;
                  end
                  step_in = P_CUSTOM;
               end
               P_CUST_W: begin
                  width_in = val;
                  step_in  = P_CUST_H;
               end
               P_CUST_H: begin
                  height_in  = val;
                  fmt_bad_in = 1'b0;
                  step_in    = P_FLAG_A;
               end
               P_SEL_C: begin
                  if (val_zero) begin
                     skip_in = 3'd2;
                     step_in = P_SKIP_C;
                  end else begin
                     step_in = P_FLAG_D;
                  end
               end
               P_SEL_D: begin
                  if (val_zero) begin
                     skip_in = 3'd2;
                     step_in = P_SKIP_D;
                  end else begin
                     step_in = P_FLAG_E;
                  end
               end
               P_SEL_F: begin
                  if (val_zero) begin
                     skip_in = 3'd4;
                     step_in = P_SKIP_F;
                  end else begin
                     step_in = P_FLAG_G;
                  end
               end
               P_SEL_G: step_in = val_zero ? P_SUB1 : P_MODE;
               P_MODE: begin
                  ilace_in = !val_zero;
                  step_in  = P_DONE;
                  done_in  = 1'b1;
               end
               P_SKIP_A, P_SKIP_B, P_SKIP_C, P_SKIP_D, P_SKIP_E,
               P_SKIP_F, P_SKIP_S1, P_SKIP_S2, P_SKIP_S3: begin
                  if (skip_ff > 3'd1) begin
                     skip_in = skip_ff - 3'd1;
                  end else begin
                     skip_in = 3'd0;
                     step_in = skip_next;
                  end
               end
               default: begin
                  step_in = P_DONE;
                  done_in = 1'b1;
               end
            endcase
         end else begin
            data_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         // write the result, then restart the parse
         if (ver_bad_ff) begin
            status_in  = RSP_BAD_VERSION;
            rwidth_in  = 32'd0;
            rheight_in = 32'd0;
            rilace_in  = 1'b0;
         end else if (fmt_bad_ff) begin
            status_in  = RSP_BAD_FORMAT;
            rwidth_in  = 32'd0;
            rheight_in = 32'd0;
            rilace_in  = 1'b0;
         end else begin
            status_in  = RSP_OK;
            rwidth_in  = w_ext[31:0];
            rheight_in = h_ext[31:0];
            rilace_in  = ilace_ff;
         end
         step_in    = P_MAJOR;
         acc_in     = ONE;
         skip_in    = 3'd0;
         width_in   = '0;
         height_in  = '0;
         fmt_bad_in = 1'b0;
         done_in    = 1'b0;
         data_in    = 1'b0;
         ver_bad_in = 1'b0;
         ilace_in   = 1'b0;
      end
   end

   // Hold parse state and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= P_MAJOR;
         acc_ff     <= ONE;
         skip_ff    <= 3'd0;
         width_ff   <= '0;
         height_ff  <= '0;
         fmt_bad_ff <= 1'b0;
         done_ff    <= 1'b0;
         data_ff    <= 1'b0;
         ver_bad_ff <= 1'b0;
         ilace_ff   <= 1'b0;
      end else begin
         step_ff    <= step_in;
         acc_ff     <= acc_in;
         skip_ff    <= skip_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         fmt_bad_ff <= fmt_bad_in;
         done_ff    <= done_in;
         data_ff    <= data_in;
         ver_bad_ff <= ver_bad_in;
         ilace_ff   <= ilace_in;
      end
      shift_ff   <= shift_in;
      status_ff  <= status_in;
      rwidth_ff  <= rwidth_in;
      rheight_ff <= rheight_in;
      rilace_ff  <= rilace_in;
   end

   assign done           = done_ff;
   assign rsp_status     = status_ff;
   assign rsp_width      = rwidth_ff;
   assign rsp_height     = rheight_ff;
   assign rsp_interlaced = rilace_ff;

`ifndef SYNTHESIS
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> done_ff)
      else $error("result written before parse end");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !cmd.emit) |=> $stable(step_ff))
      else $error("parse step moved after parse end");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/vc2_sequence_header_parser.sv
// Each header byte goes through the bit-serial decoder one bit per cycle;
// the next byte of a stream is taken while the final bit goes in.
// After the last byte, padding bits go in until the parse ends, then the
// result moves into the output register once that register is free.
// Reset is synchronous and active high; it restores the parse state and sets
// required_major to 2 and required_profile to 3.
// ----------------------------------------------------------------------------
// VC-2 sequence header parser
// Parses a sequence header byte stream and returns frame size, interlace
// and a status code once per header.
// ----------------------------------------------------------------------------
`default_nettype none

module vc2_sequence_header_parser #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   // input channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] header_byte
   input  wire         req_tlast,   // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] frame_width, [63:32] frame_height,
                                    // [64] interlaced, [71:65] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration port
   input  wire         csr_we,
   input  wire         csr_addr,
   input  wire  [7:0]  csr_wdata
);
   import vc2sh_pkg::*;

   vc2sh_cmd_type  cmd;
   vc2sh_stat_type stat;
   logic           done;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     major_ff, major_in;
   logic [7:0]     profile_ff, profile_in;
   logic [1:0]     rsp_status;
   logic [31:0]    rsp_width;
   logic [31:0]    rsp_height;
   logic           rsp_interlaced;

   // Write configuration registers
   always_comb begin
      major_in   = major_ff;
      profile_in = profile_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MAJOR:   major_in   = csr_wdata;
            CSR_PROFILE: profile_in = csr_wdata;
         endcase
      end
   end

   // Track the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff     <= MAJOR_RESET;
         profile_ff   <= PROFILE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         major_ff     <= major_in;
         profile_ff   <= profile_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.done     = done;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   vc2sh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   vc2sh_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .header_byte      (req_tdata),
      .required_major   (major_ff),
      .required_profile (profile_ff),
      .done             (done),
      .rsp_status       (rsp_status),
      .rsp_width        (rsp_width),
      .rsp_height       (rsp_height),
      .rsp_interlaced   (rsp_interlaced)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_interlaced, rsp_height, rsp_width};
   assign rsp_tuser  = rsp_status;

`ifndef SYNTHESIS
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result valid without a written result");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Sequence header parser testbench
// Streams header bytes into the parser with random gaps and result stalls,
// predicts each per-header result bit by bit in a scoreboard, and compares
// every result beat field by field. Covers the default, extreme and random
// version/profile settings, table and custom frame sizes, bad formats,
// truncated headers, trailing bytes and pure noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vc2sh_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 300;
   localparam int PHASE_BYTES   = 180;

   // Steps of the header walk, in stream order
   typedef enum logic [5:0] {
      FS_MAJOR, FS_MINOR, FS_PROFILE, FS_LEVEL, FS_FORMAT,
      FS_CUSTOM, FS_CUST_W, FS_CUST_H,
      FS_FLAG_A, FS_SKIP_A, FS_FLAG_B, FS_SKIP_B,
      FS_FLAG_C, FS_SEL_C, FS_SKIP_C,
      FS_FLAG_D, FS_SEL_D, FS_SKIP_D,
      FS_FLAG_E, FS_SKIP_E,
      FS_FLAG_F, FS_SEL_F, FS_SKIP_F,
      FS_FLAG_G, FS_SEL_G,
      FS_SUB1, FS_SKIP_S1, FS_SUB2, FS_SKIP_S2, FS_SUB3, FS_SKIP_S3,
      FS_MODE, FS_DONE
   } field_step_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] width;
      logic [31:0] height;
      logic        ilace;
   } frame_result_type;

   // -------------------------------------------------------------------------
   // Header scoreboard: walks the bit stream and queues the frame results
   // -------------------------------------------------------------------------
   class header_scoreboard;
      logic [7:0]       need_major;
      logic [7:0]       need_profile;
      field_step_type   stepq;
      logic [31:0]      acc;
      logic [2:0]       skips;
      logic [31:0]      fw;
      logic [31:0]      fh;
      bit               fmt_bad;
      bit               done;
      bit               in_data;
      bit               ver_bad;
      bit               ilace;
      frame_result_type frames_q[$];
      int               errors;

      function new();
         need_major   = MAJOR_RESET;
         need_profile = PROFILE_RESET;
         errors       = 0;
         restart();
      endfunction

      function void restart();
         stepq   = FS_MAJOR;
         acc     = 32'd1;
         skips   = 3'd0;
         fw      = 32'd0;
         fh      = 32'd0;
         fmt_bad = 1'b0;
         done    = 1'b0;
         in_data = 1'b0;
         ver_bad = 1'b0;
         ilace   = 1'b0;
      endfunction

      function void set_reg(logic addr, logic [7:0] val);
         if (addr == CSR_MAJOR) need_major = val;
         else need_profile = val;
      endfunction

      function int pending();
         return frames_q.size();
      endfunction

      // base video format sizes
      function void base_size(logic [4:0] idx, output logic [31:0] w, output logic [31:0] h);
         case (idx)
            5'd0:    begin w = 640;  h = 480;  end
            5'd1:    begin w = 176;  h = 120;  end
            5'd2:    begin w = 176;  h = 144;  end
            5'd3:    begin w = 352;  h = 240;  end
            5'd4:    begin w = 352;  h = 288;  end
            5'd5:    begin w = 704;  h = 480;  end
            5'd6:    begin w = 704;  h = 576;  end
            5'd7:    begin w = 720;  h = 480;  end
            5'd8:    begin w = 720;  h = 576;  end
            5'd9:    begin w = 1280; h = 720;  end
            5'd10:   begin w = 1280; h = 720;  end
            5'd11:   begin w = 1920; h = 1080; end
            5'd12:   begin w = 1920; h = 1080; end
            5'd13:   begin w = 1920; h = 1080; end
            5'd14:   begin w = 1920; h = 1080; end
            5'd15:   begin w = 2048; h = 1080; end
            5'd16:   begin w = 4096; h = 2160; end
            5'd17:   begin w = 3840; h = 2160; end
            5'd18:   begin w = 3840; h = 2160; end
            5'd19:   begin w = 7680; h = 4320; end
            5'd20:   begin w = 7680; h = 4320; end
            5'd21:   begin w = 1920; h = 1080; end
            default: begin w = 720;  h = 486;  end
         endcase
      endfunction

      function bit is_flag(field_step_type s);
         case (s)
            FS_CUSTOM, FS_FLAG_A, FS_FLAG_B, FS_FLAG_C, FS_FLAG_D, FS_FLAG_E,
            FS_FLAG_F, FS_FLAG_G, FS_SUB1, FS_SUB2, FS_SUB3: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void go_skip(logic [2:0] count, field_step_type s);
         skips = count;
         stepq = s;
      endfunction

      function field_step_type skip_target(field_step_type s);
         case (s)
            FS_SKIP_A:  return FS_FLAG_B;
            FS_SKIP_B:  return FS_FLAG_C;
            FS_SKIP_C:  return FS_FLAG_D;
            FS_SKIP_D:  return FS_FLAG_E;
            FS_SKIP_E:  return FS_FLAG_F;
            FS_SKIP_F:  return FS_FLAG_G;
            FS_SKIP_S1: return FS_SUB2;
            FS_SKIP_S2: return FS_SUB3;
            default:    return FS_MODE;
         endcase
      endfunction

      function void take_flag(bit b);
         case (stepq)
            FS_CUSTOM: stepq = b ? FS_CUST_W : FS_FLAG_A;
            FS_FLAG_A: if (b) go_skip(3'd1, FS_SKIP_A); else stepq = FS_FLAG_B;
            FS_FLAG_B: if (b) go_skip(3'd1, FS_SKIP_B); else stepq = FS_FLAG_C;
            FS_FLAG_C: stepq = b ? FS_SEL_C : FS_FLAG_D;
            FS_FLAG_D: stepq = b ? FS_SEL_D : FS_FLAG_E;
            FS_FLAG_E: if (b) go_skip(3'd4, FS_SKIP_E); else stepq = FS_FLAG_F;
            FS_FLAG_F: stepq = b ? FS_SEL_F : FS_FLAG_G;
            FS_FLAG_G: stepq = b ? FS_SEL_G : FS_MODE;
            FS_SUB1:   if (b) go_skip(3'd1, FS_SKIP_S1); else stepq = FS_SUB2;
            FS_SUB2:   if (b) go_skip(3'd1, FS_SKIP_S2); else stepq = FS_SUB3;
            FS_SUB3:   if (b) go_skip(3'd1, FS_SKIP_S3); else stepq = FS_MODE;
            default: ;
         endcase
      endfunction

      function void take_value(logic [31:0] v);
         case (stepq)
            FS_MAJOR: begin
               if (v != {24'd0, need_major}) ver_bad = 1'b1;
               stepq = FS_MINOR;
            end
            FS_MINOR: stepq = FS_PROFILE;
            FS_PROFILE: begin
               if (v != {24'd0, need_profile}) ver_bad = 1'b1;
               stepq = FS_LEVEL;
            end
            FS_LEVEL: begin
               // a rejected header stops right after the level
               if (ver_bad) begin
                  stepq = FS_DONE;
                  done  = 1'b1;
               end else begin
                  stepq = FS_FORMAT;
               end
            end
            FS_FORMAT: begin
               if (v < FORMAT_COUNT) begin
                  base_size(v[4:0], fw, fh);
                  fmt_bad = 1'b0;
               end else begin
                  fw      = 32'd0;
                  fh      = 32'd0;
                  fmt_bad = 1'b1;
               end
               stepq = FS_CUSTOM;
            end
            FS_CUST_W: begin
               fw    = v;
               stepq = FS_CUST_H;
            end
            FS_CUST_H: begin
               // custom size makes an unknown index harmless
               fh      = v;
               fmt_bad = 1'b0;
               stepq   = FS_FLAG_A;
            end
            FS_SEL_C: if (v == 0) go_skip(3'd2, FS_SKIP_C); else stepq = FS_FLAG_D;
            FS_SEL_D: if (v == 0) go_skip(3'd2, FS_SKIP_D); else stepq = FS_FLAG_E;
            FS_SEL_F: if (v == 0) go_skip(3'd4, FS_SKIP_F); else stepq = FS_FLAG_G;
            FS_SEL_G: stepq = (v == 0) ? FS_SUB1 : FS_MODE;
            FS_MODE: begin
               ilace = (v != 0);
               stepq = FS_DONE;
               done  = 1'b1;
            end
            FS_SKIP_A, FS_SKIP_B, FS_SKIP_C, FS_SKIP_D, FS_SKIP_E, FS_SKIP_F,
            FS_SKIP_S1, FS_SKIP_S2, FS_SKIP_S3: begin
               if (skips > 3'd1) begin
                  skips = skips - 3'd1;
               end else begin
                  skips = 3'd0;
                  stepq = skip_target(stepq);
               end
            end
            default: begin
               stepq = FS_DONE;
               done  = 1'b1;
            end
         endcase
      endfunction

      // interleaved exp-Golomb: 0 then a data bit, or 1 to close the value
      function void take_bit(bit b);
         logic [31:0] v;
         if (!done) begin
            if (is_flag(stepq)) begin
               take_flag(b);
            end else if (in_data) begin
               acc     = {acc[30:0], b};
               in_data = 1'b0;
            end else if (b) begin
               v   = acc - 32'd1;
               acc = 32'd1;
               take_value(v);
            end else begin
               in_data = 1'b1;
            end
         end
      endfunction

      function void note_input(logic [7:0] data, logic last);
         frame_result_type e;
         int               n;
         for (n = 7; n >= 0; n--) take_bit(data[n]);
         if (last) begin
            // a short header reads as all ones until the walk ends
            for (n = 0; n < 256 && !done; n++) take_bit(1'b1);
            e = '0;
            if (ver_bad) begin
               e.status = RSP_BAD_VERSION;
            end else if (fmt_bad) begin
               e.status = RSP_BAD_FORMAT;
            end else begin
               e.status = RSP_OK;
               e.width  = fw;
               e.height = ilace ? (fh >> 1) : fh;
               e.ilace  = ilace;
            end
            frames_q.push_back(e);
            restart();
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [1:0] st, logic [31:0] w, logic [31:0] h, logic il,
                        logic [6:0] pad);
         frame_result_type e;
         if (frames_q.size() == 0) begin
            report("result beat with no frame expected");
         end else begin
            e = frames_q.pop_front();
            if (st !== e.status)
               report($sformatf("status got %0d want %0d", st, e.status));
            if (w !== e.width)
               report($sformatf("frame_width got %0d want %0d", w, e.width));
            if (h !== e.height)
               report($sformatf("frame_height got %0d want %0d", h, e.height));
            if (il !== e.ilace)
               report($sformatf("interlaced got %0d want %0d", il, e.ilace));
            if (pad !== 7'd0)
               report($sformatf("tdata fill bits got %h", pad));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT and signals
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] header_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // [31:0] frame_width, [63:32] frame_height,
                             // [64] interlaced, [71:65] zero
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        csr_we;
   logic        csr_addr;
   logic [7:0]  csr_wdata;

   header_scoreboard sb = new();

   logic [7:0] cur_major;
   logic [7:0] cur_profile;
   bit         hdr_bits[$];
   int         bytes_sent;
   int         req_burst;
   int         rsp_burst;
   int         cycle_count;

   vc2_sequence_header_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap draw: mostly 0..17, with occasional stretches of back-to-back beats
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0) burst = $urandom_range(10, 40);
      return $urandom_range(0, 17);
   endfunction

   // -------------------------------------------------------------------------
   // Header bit builder
   // -------------------------------------------------------------------------
   function automatic void push_code(int nbits, logic [63:0] tail);
      for (int i = nbits - 1; i >= 0; i--) begin
         hdr_bits.push_back(1'b0);
         hdr_bits.push_back(tail[i]);
      end
      hdr_bits.push_back(1'b1);
   endfunction

   function automatic void push_uint(logic [31:0] v);
      logic [32:0] x;
      int          n;
      x = {1'b0, v} + 33'd1;
      n = 0;
      for (int k = 0; k <= 32; k++) if (x[k]) n = k;
      push_code(n, {31'd0, x});
   endfunction

   function automatic logic [31:0] rnd_value();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         5:       return $urandom_range(0, 65535);
         6:       return $urandom;
         7:       return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 20);
      endcase
   endfunction

   // flag followed, when set, by a fixed number of skipped values
   function automatic void push_flag_skip(int count);
      if ($urandom_range(0, 1)) begin
         hdr_bits.push_back(1'b1);
         repeat (count) push_uint(rnd_value());
      end else begin
         hdr_bits.push_back(1'b0);
      end
   endfunction

   // flag, then a selector; selector zero brings skipped values
   function automatic void push_selector(int count);
      logic [31:0] sel;
      if ($urandom_range(0, 1)) begin
         hdr_bits.push_back(1'b1);
         sel = $urandom_range(0, 1) ? 32'd0 : rnd_value();
         push_uint(sel);
         if (sel == 0) repeat (count) push_uint(rnd_value());
      end else begin
         hdr_bits.push_back(1'b0);
      end
   endfunction

   function automatic void build_header(logic [31:0] major, logic [31:0] minor,
                                        logic [31:0] profile, logic [31:0] level,
                                        logic [31:0] fmt, bit custom, bit wide,
                                        logic [31:0] cw, logic [31:0] ch,
                                        bit rand_opts, logic [31:0] mode);
      logic [31:0] sel;
      hdr_bits.delete();
      push_uint(major);
      push_uint(minor);
      push_uint(profile);
      push_uint(level);
      push_uint(fmt);
      hdr_bits.push_back(custom);
      if (custom) begin
         // wide codes overflow the 32-bit accumulator
         if (wide) push_code($urandom_range(33, 40), {$urandom, $urandom});
         else push_uint(cw);
         if (wide) push_code($urandom_range(33, 40), {$urandom, $urandom});
         else push_uint(ch);
      end
      if (rand_opts) begin
         push_flag_skip(1);
         push_flag_skip(1);
         push_selector(2);
         push_selector(2);
         push_flag_skip(4);
         push_selector(4);
         if ($urandom_range(0, 1)) begin
            hdr_bits.push_back(1'b1);
            sel = $urandom_range(0, 1) ? 32'd0 : rnd_value();
            push_uint(sel);
            if (sel == 0) repeat (3) push_flag_skip(1);
         end else begin
            hdr_bits.push_back(1'b0);
         end
      end else begin
         repeat (7) hdr_bits.push_back(1'b0);
      end
      push_uint(mode);
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_beat(input logic [7:0] data, input logic last);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(data, last);
      bytes_sent++;
   endtask

   // pack the built bits MSB first, optionally cut short, then trailing bytes
   task automatic send_header(input bit truncate, input int extra);
      logic [7:0] cur;
      logic [7:0] hdr_bytes[$];
      int         keep;
      int         i;
      keep = hdr_bits.size();
      if (truncate && keep > 1) keep = $urandom_range(1, keep - 1);
      cur = 8'd0;
      for (i = 0; i < keep; i++) begin
         cur = {cur[6:0], hdr_bits[i]};
         if (i % 8 == 7) begin
            hdr_bytes.push_back(cur);
            cur = 8'd0;
         end
      end
      if (keep % 8 != 0) begin
         for (i = keep % 8; i < 8; i++) cur = {cur[6:0], 1'($urandom_range(0, 1))};
         hdr_bytes.push_back(cur);
      end
      repeat (extra) hdr_bytes.push_back(8'($urandom));
      for (i = 0; i < hdr_bytes.size(); i++)
         send_beat(hdr_bytes[i], i == hdr_bytes.size() - 1);
   endtask

   // hold the sender until every queued frame has come back
   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] major, input logic [7:0] profile);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MAJOR;
      csr_wdata <= major;
      @(posedge clock);
      csr_addr  <= CSR_PROFILE;
      csr_wdata <= profile;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(CSR_MAJOR, major);
      sb.set_reg(CSR_PROFILE, profile);
      cur_major   = major;
      cur_profile = profile;
   endtask

   task automatic run_directed();
      // table format, progressive
      build_header(2, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0);
      send_header(0, 0);
      // largest table format, interlaced
      build_header(2, 1, 3, 4, 19, 0, 0, 0, 0, 0, 1);
      send_header(0, 0);
      // wrong major, then wrong profile
      build_header(5, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0);
      send_header(0, 0);
      build_header(2, 0, 9, 0, 0, 0, 0, 0, 0, 0, 0);
      send_header(0, 0);
      // index just past the table, no custom size
      build_header(2, 0, 3, 0, 23, 0, 0, 0, 0, 0, 0);
      send_header(0, 0);
      // unknown index rescued by a custom size, odd height halved
      build_header(2, 0, 3, 0, 40, 1, 0, 1, 3, 0, 2);
      send_header(0, 0);
      // last table entry with trailing bytes after the parse ends
      build_header(2, 0, 3, 0, 22, 0, 0, 0, 0, 0, 0);
      send_header(0, 2);
      // all-ones and all-zeros single-byte headers
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);
      // header cut short, finished by padding
      build_header(2, 0, 3, 0, 11, 0, 0, 0, 0, 0, 0);
      send_header(1, 0);
   endtask

   task automatic run_random(input int goal);
      int          start;
      int          r;
      int          n;
      logic [31:0] fmt;
      start = bytes_sent;
      while (bytes_sent - start < goal) begin
         r = $urandom_range(0, 19);
         if (r < 2) begin
            // noise run
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) send_beat(8'($urandom), i == n - 1);
         end else begin
            case ($urandom_range(0, 15))
               0, 1:    fmt = $urandom_range(23, 31);
               2:       fmt = rnd_value();
               default: fmt = $urandom_range(0, 22);
            endcase
            build_header((r == 2) ? rnd_value() : {24'd0, cur_major}, rnd_value(),
                         (r == 3) ? rnd_value() : {24'd0, cur_profile}, rnd_value(),
                         fmt, $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0,
                         rnd_value(), rnd_value(), 1,
                         $urandom_range(0, 1) ? 32'd0 : rnd_value());
            send_header($urandom_range(0, 7) == 0,
                        ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
         end
         if ($urandom_range(0, 24) == 0) wait_results();
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls, check each accepted beat
   // -------------------------------------------------------------------------
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[64],
                         rsp_tdata[71:65]);
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bytes_sent  = 0;
      req_burst   = 0;
      rsp_burst   = 0;
      cur_major   = MAJOR_RESET;
      cur_profile = PROFILE_RESET;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_MAJOR;
      csr_wdata  <= 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_BYTES);
      settle();
      write_regs(8'd0, 8'd0);
      run_random(PHASE_BYTES);
      settle();
      write_regs(8'd255, 8'd255);
      run_random(PHASE_BYTES);
      settle();
      write_regs(8'($urandom), 8'($urandom));
      run_random(PHASE_BYTES);
      settle();
      write_regs(MAJOR_RESET, PROFILE_RESET);
      run_random(PHASE_BYTES);
      settle();

      if (sb.pending() != 0) sb.report("frames still expected at end of run");
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/vc2sh_pkg.sv
hw/rtl/vc2sh_ctrl.sv
hw/rtl/vc2sh_dpath.sv
hw/rtl/vc2_sequence_header_parser.sv
tb/tb.sv
